// ===== src/pclru_pkg.sv =====
package pclru_pkg;

  // Default geometry of the directory
  localparam int PAGE_BYTES = 16384;
  localparam int SLOT_COUNT = 16;

  // Fixed field widths
  localparam int OFFSET_W   = 32;
  localparam int STORE_W    = 32;
  localparam int SLOT_OUT_W = 4;
  localparam int PAGE_OUT_W = 18;
  localparam int LEN_OUT_W  = 15;
  localparam int ADDR_OUT_W = 18;

  // Controller to datapath commands, one per phase
  typedef struct packed {
    logic take;
    logic check;
    logic scan;
    logic resolve;
    logic update;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic oor;
    logic scan_done;
    logic upd_done;
    logic out_free;
  } sts_t;

endpackage

// ===== src/pclru_if.sv =====
interface pclru_in_if;
  logic                         valid;
  logic                         ready;
  logic [pclru_pkg::OFFSET_W-1:0] byte_offset;

  modport source (output valid, output byte_offset, input ready);
  modport sink (input valid, input byte_offset, output ready);
endinterface

interface pclru_out_if;
  logic                           valid;
  logic                           ready;
  logic                           out_of_range;
  logic                           hit;
  logic [pclru_pkg::SLOT_OUT_W-1:0] slot;
  logic [pclru_pkg::PAGE_OUT_W-1:0] fetch_page;
  logic [pclru_pkg::LEN_OUT_W-1:0]  fetch_length;
  logic [pclru_pkg::ADDR_OUT_W-1:0] data_address;

  modport source (
    output valid, output out_of_range, output hit, output slot,
    output fetch_page, output fetch_length, output data_address,
    input ready
  );
  modport sink (
    input valid, input out_of_range, input hit, input slot,
    input fetch_page, input fetch_length, input data_address,
    output ready
  );
endinterface

// ===== src/pclru_ctrl.sv =====
module pclru_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pclru_pkg::sts_t sts,
  output pclru_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_RESOLVE,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Take a new beat only between lookups
  assign in_ready = (state_r == ST_IDLE);

  // Decode phase commands
  always_comb begin
    cmd         = '0;
    cmd.take    = (state_r == ST_IDLE) && in_valid;
    cmd.check   = (state_r == ST_CHECK);
    cmd.scan    = (state_r == ST_SCAN);
    cmd.resolve = (state_r == ST_RESOLVE);
    cmd.update  = (state_r == ST_UPDATE);
    cmd.finish  = (state_r == ST_FINISH);
  end

  // Advance through the lookup phases
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = sts.oor ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts.upd_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/pclru_dp.sv =====
module pclru_dp #(
  parameter int PAGE_BYTES = pclru_pkg::PAGE_BYTES,
  parameter int SLOT_COUNT = pclru_pkg::SLOT_COUNT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pclru_pkg::cmd_t                  cmd,
  output pclru_pkg::sts_t                  sts,
  input  logic                             cfg_we,
  input  logic [pclru_pkg::STORE_W-1:0]    cfg_wdata,
  input  logic [pclru_pkg::OFFSET_W-1:0]   in_byte_offset,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_of_range,
  output logic                             out_hit,
  output logic [pclru_pkg::SLOT_OUT_W-1:0] out_slot,
  output logic [pclru_pkg::PAGE_OUT_W-1:0] out_fetch_page,
  output logic [pclru_pkg::LEN_OUT_W-1:0]  out_fetch_length,
  output logic [pclru_pkg::ADDR_OUT_W-1:0] out_data_address
);

  localparam int OFF_W      = pclru_pkg::OFFSET_W;
  localparam int ST_W       = pclru_pkg::STORE_W;
  localparam int SO_W       = pclru_pkg::SLOT_OUT_W;
  localparam int PO_W       = pclru_pkg::PAGE_OUT_W;
  localparam int LO_W       = pclru_pkg::LEN_OUT_W;
  localparam int AO_W       = pclru_pkg::ADDR_OUT_W;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int TAG_W      = OFF_W - PAGE_SHIFT;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam logic [ST_W-1:0]  PAGE_LEN  = ST_W'(PAGE_BYTES);
  localparam logic [CNT_W-1:0] SLOT_FULL = CNT_W'(SLOT_COUNT);

  // Directory storage
  logic [TAG_W-1:0]  tag_mem  [SLOT_COUNT];
  logic [SLOT_W-1:0] rank_mem [SLOT_COUNT];

  logic [ST_W-1:0]   store_size_r;
  logic [OFF_W-1:0]  off_r;
  logic [TAG_W-1:0]  tag_q_r;
  logic [SLOT_W-1:0] rank_q_r;
  logic [CNT_W-1:0]  idx_r;
  logic              rd_vld_r;
  logic [SLOT_W-1:0] rd_idx_r;
  logic              found_r;
  logic [SLOT_W-1:0] match_slot_r;
  logic [SLOT_W-1:0] match_rank_r;
  logic [SLOT_W-1:0] vic_slot_r;
  logic [SLOT_W-1:0] worst_r;
  logic [CNT_W-1:0]  filled_r;
  logic              grow_r;
  logic [SLOT_W-1:0] s_r;
  logic [CNT_W-1:0]  old_r;

  logic              res_oor_r;
  logic              res_hit_r;
  logic [SO_W-1:0]   res_slot_r;
  logic [PO_W-1:0]   res_page_r;
  logic [LO_W-1:0]   res_len_r;
  logic [AO_W-1:0]   res_addr_r;

  logic              out_vld_r;
  logic              out_oor_r;
  logic              out_hit_r;
  logic [SO_W-1:0]   out_slot_r;
  logic [PO_W-1:0]   out_page_r;
  logic [LO_W-1:0]   out_len_r;
  logic [AO_W-1:0]   out_addr_r;

  logic [TAG_W-1:0]         page;
  logic [OFF_W-1:0]         base;
  logic [ST_W-1:0]          span;
  logic [ST_W-1:0]          len;
  logic                     oor;
  logic                     full;
  logic                     issue_scan;
  logic                     issue_upd;
  logic                     out_free;
  logic [SLOT_W-1:0]        s_nxt;
  logic [CNT_W-1:0]         old_nxt;
  logic [SLOT_W+PAGE_SHIFT-1:0] addr_full;
  logic                     rank_we;
  logic [SLOT_W-1:0]        rank_waddr;
  logic [SLOT_W-1:0]        rank_wdata;
  logic                     tag_we;

  // Split the offset into page and page base
  assign page = off_r[OFF_W-1:PAGE_SHIFT];
  assign base = {page, {PAGE_SHIFT{1'b0}}};
  assign oor  = (off_r >= store_size_r);
  assign full = (filled_r == SLOT_FULL);

  // Walk the filled slots one read per cycle
  assign issue_scan = cmd.scan && !found_r && (idx_r != filled_r);
  assign issue_upd  = cmd.update && (idx_r != filled_r);
  assign out_free   = !out_vld_r || out_ready;

  always_comb begin
    sts           = '0;
    sts.oor       = oor;
    sts.scan_done = !rd_vld_r && (found_r || (idx_r == filled_r));
    sts.upd_done  = !rd_vld_r && (idx_r == filled_r);
    sts.out_free  = out_free;
  end

  // Pick the slot and the rank it leaves
  always_comb begin
    if (found_r) begin
      s_nxt   = match_slot_r;
      old_nxt = CNT_W'(match_rank_r);
    end else if (!full) begin
      s_nxt   = filled_r[SLOT_W-1:0];
      old_nxt = SLOT_FULL;
    end else begin
      s_nxt   = vic_slot_r;
      old_nxt = CNT_W'(worst_r);
    end
  end

  // Clip the fetch at the end of the store
  assign span      = store_size_r - base;
  assign len       = (span > PAGE_LEN) ? PAGE_LEN : span;
  assign addr_full = {s_nxt, off_r[PAGE_SHIFT-1:0]};

  // Rank write: new slot gets 0; update zeroes used slot, ages younger
  always_comb begin
    rank_we    = 1'b0;
    rank_waddr = rd_idx_r;
    rank_wdata = '0;
    if (cmd.resolve && !found_r && !full) begin
      rank_we    = 1'b1;
      rank_waddr = s_nxt;
    end else if (cmd.update && rd_vld_r) begin
      rank_we    = 1'b1;
      if (rd_idx_r == s_r) begin
        rank_wdata = '0;
      end else if (CNT_W'(rank_q_r) < old_r) begin
        rank_wdata = rank_q_r + 1'b1;
      end else begin
        rank_wdata = rank_q_r;
      end
    end
  end

  assign tag_we = cmd.resolve && !found_r;

  // Tag memory
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[s_nxt] <= page;
    end
    if (issue_scan) begin
      tag_q_r <= tag_mem[idx_r[SLOT_W-1:0]];
    end
  end

  // Rank memory
  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    if (issue_scan || issue_upd) begin
      rank_q_r <= rank_mem[idx_r[SLOT_W-1:0]];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_size_r <= '0;
      filled_r     <= '0;
      idx_r        <= '0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      grow_r       <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        store_size_r <= cfg_wdata;
      end
      rd_vld_r <= issue_scan || issue_upd;
      if (issue_scan || issue_upd) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.take) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        grow_r  <= 1'b0;
      end
      if (cmd.scan && rd_vld_r && !found_r && (tag_q_r == page)) begin
        found_r <= 1'b1;
      end
      if (cmd.resolve) begin
        idx_r  <= '0;
        grow_r <= !found_r && !full;
      end
      // Hand the result over and drop it once taken
      if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cmd.finish && out_free) begin
        out_vld_r <= 1'b1;
        if (grow_r) begin
          filled_r <= filled_r + 1'b1;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      off_r      <= in_byte_offset;
      worst_r    <= '0;
      vic_slot_r <= '0;
    end
    if (issue_scan || issue_upd) begin
      rd_idx_r <= idx_r[SLOT_W-1:0];
    end
    // Compare the returned tag and track the oldest slot
    if (cmd.scan && rd_vld_r && !found_r) begin
      if (tag_q_r == page) begin
        match_slot_r <= rd_idx_r;
        match_rank_r <= rank_q_r;
      end
      if (rank_q_r > worst_r) begin
        worst_r    <= rank_q_r;
        vic_slot_r <= rd_idx_r;
      end
    end
    if (cmd.check) begin
      res_oor_r  <= oor;
      res_hit_r  <= 1'b0;
      res_slot_r <= '0;
      res_page_r <= '0;
      res_len_r  <= '0;
      res_addr_r <= '0;
    end
    if (cmd.resolve) begin
      s_r        <= s_nxt;
      old_r      <= old_nxt;
      res_hit_r  <= found_r;
      res_slot_r <= SO_W'(s_nxt);
      res_page_r <= found_r ? '0 : PO_W'(page);
      res_len_r  <= found_r ? '0 : LO_W'(len);
      res_addr_r <= AO_W'(addr_full);
    end
    if (cmd.finish && out_free) begin
      out_oor_r  <= res_oor_r;
      out_hit_r  <= res_hit_r;
      out_slot_r <= res_slot_r;
      out_page_r <= res_page_r;
      out_len_r  <= res_len_r;
      out_addr_r <= res_addr_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_of_range     = out_oor_r;
  assign out_hit          = out_hit_r;
  assign out_slot         = out_slot_r;
  assign out_fetch_page   = out_page_r;
  assign out_fetch_length = out_len_r;
  assign out_data_address = out_addr_r;

endmodule

// ===== src/page_cache_lru_directory_top.sv =====
// For an out-of-range offset the result goes from the check phase through the finish phase
// to the output register; otherwise the lookup does one tag read per filled slot, until a match,
// then one rank read-modify-write per filled slot, plus any wait for the output register.
// One lookup is handled at a time; the next beat is taken the cycle after the result
// register loads, while that result may wait.
// Reset clears the store size, the fill count and the handshakes; tags and ranks are not.
module page_cache_lru_directory_top #(
  parameter int PAGE_BYTES = pclru_pkg::PAGE_BYTES,
  parameter int SLOT_COUNT = pclru_pkg::SLOT_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pclru_in_if.sink                      in_ch,
  pclru_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [pclru_pkg::STORE_W-1:0] cfg_wdata
);

  pclru_pkg::cmd_t cmd;
  pclru_pkg::sts_t sts;

  // Sequence the lookup phases
  pclru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold tags, ranks and the result register
  pclru_dp #(
    .PAGE_BYTES (PAGE_BYTES),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_byte_offset   (in_ch.byte_offset),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_of_range     (out_ch.out_of_range),
    .out_hit          (out_ch.hit),
    .out_slot         (out_ch.slot),
    .out_fetch_page   (out_ch.fetch_page),
    .out_fetch_length (out_ch.fetch_length),
    .out_data_address (out_ch.data_address)
  );

endmodule
